@@ hdl/bvt_pkg.sv @@
// ----------------------------------------------------------------------------
// bvt_pkg: box vertex transform and axis query package
// Shared widths, fixed-point constants, request kinds, register indexes,
// sequencer states and the box corner selection table.
// ----------------------------------------------------------------------------
package bvt_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 32;
    localparam int WORD_W     = 32;
    localparam int PROJ_BITS  = 48;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int SHP_W      = PROD_W - FRAC_BITS;
    localparam int ACC_W      = SHP_W + 2;

    // Vertex and matrix geometry
    localparam int NUM_VERTS = 8;
    localparam int VTX_W     = $clog2(NUM_VERTS);
    localparam int NUM_ROWS  = 3;
    localparam int NUM_COLS  = 4;

    // Stream payload widths
    localparam int S_TDATA_W = 7 * WORD_W;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 2 * PROJ_BITS + 3 * WORD_W;

    // Configuration port
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [PROJ_BITS-1:0] t_proj;

    // 1.0 in the fixed-point format
    localparam t_word ONE_FX     = t_word'(64'sd1 <<< FRAC_BITS);
    localparam t_word NEG_ONE_FX = t_word'(-(64'sd1 <<< FRAC_BITS));

    // Saturation bounds held at accumulator width
    localparam t_acc COORD_HI = t_acc'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam t_acc COORD_LO = t_acc'(-(64'sd1 <<< (COORD_BITS - 1)));
    localparam t_acc PROJ_HI  = t_acc'((64'sd1 <<< (PROJ_BITS - 1)) - 64'sd1);
    localparam t_acc PROJ_LO  = t_acc'(-(64'sd1 <<< (PROJ_BITS - 1)));

    // Translation column, last product term and last row of the affine matrix
    localparam logic [1:0] TRANS_COL = 2'd3;
    localparam logic [1:0] LAST_TERM = 2'd2;
    localparam logic [1:0] LAST_ROW  = 2'd2;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_APPLY = 2'd1,
        REQ_QUERY = 2'd2
    } t_req_kind;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SAT,
        ST_STORE,
        ST_DONE
    } t_state;

    // Corner order (x,n,n) (x,n,x) (n,n,x) (n,n,n) (x,x,n) (x,x,x) (n,x,x) (n,x,n):
    // return 1 when the given axis of the vertex takes the box maximum
    function automatic logic corner_hi(input logic [VTX_W-1:0] vtx, input logic [1:0] axis);
        logic sel;
        case (axis)
            2'd0:    sel = ~vtx[1];
            2'd1:    sel = vtx[2];
            default: sel = vtx[0] ^ vtx[1];
        endcase
        return sel;
    endfunction

endpackage

@@ hdl/box_vertex_transform_and_axis_query.sv @@
// ----------------------------------------------------------------------------
// box_vertex_transform_and_axis_query: transformed box corners and axis query
// Holds a 3x4 affine matrix and eight box vertices; transforms the configured
// reference corners and projects the vertices onto a query axis with one
// shared 32x32 multiplier and accumulator.
// ----------------------------------------------------------------------------
// A load request writes its matrix row on acceptance; an apply transforms
// 24 coordinates (3 rows x 8 vertices); a query projects the eight vertices
// and posts its result from the done state once the output register is free.
// One request at a time; a multiply and an accumulate step per product, then
// saturate and store; a posted result waits in the output register meanwhile.
// Reset (synchronous, active low) restores the identity matrix, the +-1.0 box and its corners.
// ----------------------------------------------------------------------------
module box_vertex_transform_and_axis_query (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [bvt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bvt_pkg::WORD_W-1:0]          i_cfg_data,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: coef_0, coef_1, coef_2, coef_3, axis_x, axis_y, axis_z (32 each)
    input  logic [bvt_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // tuser: req_type [1:0], row_index [3:2]
    input  logic [bvt_pkg::S_TUSER_W-1:0]       i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: interval_min (48), interval_max (48), support_x, support_y,
    //        support_z (32 each)
    output logic [bvt_pkg::M_TDATA_W-1:0]       o_m_axis_tdata
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    bvt_pkg::t_state r_state, n_state;

    bvt_pkg::t_word r_box_lo [3];
    bvt_pkg::t_word r_box_hi [3];
    bvt_pkg::t_word r_matrix [bvt_pkg::NUM_ROWS][bvt_pkg::NUM_COLS];
    bvt_pkg::t_word r_vertex [bvt_pkg::NUM_VERTS][3];
    bvt_pkg::t_word r_axis   [3];
    bvt_pkg::t_word r_vtmp   [3];
    bvt_pkg::t_word r_supp   [3];

    logic                           r_apply;
    logic [bvt_pkg::VTX_W-1:0]      r_vtx;
    logic [1:0]                     r_row;
    logic [1:0]                     r_term;

    logic signed [bvt_pkg::PROD_W-1:0] r_prod;
    bvt_pkg::t_acc                  r_acc;
    bvt_pkg::t_acc                  r_sat;
    bvt_pkg::t_proj                 r_lo;
    bvt_pkg::t_proj                 r_hi;

    logic                           r_out_valid;
    logic [bvt_pkg::M_TDATA_W-1:0]  r_out_data;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                   w_accept;
    bvt_pkg::t_req_kind     w_kind;
    logic [1:0]             w_row_in;
    logic                   w_out_free;

    assign w_kind     = bvt_pkg::t_req_kind'(i_s_axis_tuser[1:0]);
    assign w_row_in   = i_s_axis_tuser[3:2];
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bvt_pkg::ST_IDLE: begin
                if (w_accept && (w_kind == bvt_pkg::REQ_APPLY ||
                                 w_kind == bvt_pkg::REQ_QUERY)) begin
                    n_state = bvt_pkg::ST_MUL;
                end
            end
            bvt_pkg::ST_MUL: begin
                n_state = bvt_pkg::ST_ACC;
            end
            bvt_pkg::ST_ACC: begin
                n_state = (r_term == bvt_pkg::LAST_TERM) ? bvt_pkg::ST_SAT : bvt_pkg::ST_MUL;
            end
            bvt_pkg::ST_SAT: begin
                n_state = bvt_pkg::ST_STORE;
            end
            bvt_pkg::ST_STORE: begin
                if (r_vtx == bvt_pkg::VTX_W'(bvt_pkg::NUM_VERTS - 1) &&
                    (!r_apply || r_row == bvt_pkg::LAST_ROW)) begin
                    n_state = r_apply ? bvt_pkg::ST_IDLE : bvt_pkg::ST_DONE;
                end else begin
                    n_state = bvt_pkg::ST_MUL;
                end
            end
            bvt_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = bvt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bvt_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath controls
    // ------------------------------------------------------------------
    bvt_pkg::t_word w_op_a;
    bvt_pkg::t_word w_op_b;
    bvt_pkg::t_acc  w_shp;
    bvt_pkg::t_acc  w_init;
    bvt_pkg::t_acc  w_sat_hi;
    bvt_pkg::t_acc  w_sat_lo;
    bvt_pkg::t_proj w_p;
    logic signed [bvt_pkg::PROD_W-1:0] w_shift;

    always_comb begin
        o_s_axis_tready = (r_state == bvt_pkg::ST_IDLE);
        // operand select for the shared multiplier
        if (r_apply) begin
            w_op_a = r_matrix[r_row][r_term];
            w_op_b = bvt_pkg::corner_hi(r_vtx, r_term) ? r_box_hi[r_term]
                                                        : r_box_lo[r_term];
        end else begin
            w_op_a = r_vertex[r_vtx][r_term];
            w_op_b = r_axis[r_term];
        end
        // floor shift of the product, then extend to accumulator width
        w_shift  = r_prod >>> bvt_pkg::FRAC_BITS;
        w_shp    = bvt_pkg::t_acc'($signed(w_shift[bvt_pkg::SHP_W-1:0]));
        w_init   = r_apply ? bvt_pkg::t_acc'(r_matrix[r_row][bvt_pkg::TRANS_COL]) : '0;
        w_sat_hi = r_apply ? bvt_pkg::COORD_HI : bvt_pkg::PROJ_HI;
        w_sat_lo = r_apply ? bvt_pkg::COORD_LO : bvt_pkg::PROJ_LO;
        w_p      = r_sat[bvt_pkg::PROJ_BITS-1:0];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Sequencer state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bvt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bvt_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Post the query result
    always_ff @(posedge i_clk) begin
        if (r_state == bvt_pkg::ST_DONE && w_out_free) begin
            r_out_data <= {r_supp[2], r_supp[1], r_supp[0], r_hi, r_lo};
        end
    end

    // ------------------------------------------------------------------
    // Box registers, matrix and vertex store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                r_box_lo[c] <= bvt_pkg::NEG_ONE_FX;
                r_box_hi[c] <= bvt_pkg::ONE_FX;
            end
            for (int r = 0; r < bvt_pkg::NUM_ROWS; r++) begin
                for (int c = 0; c < bvt_pkg::NUM_COLS; c++) begin
                    r_matrix[r][c] <= (r == c) ? bvt_pkg::ONE_FX : '0;
                end
            end
            for (int v = 0; v < bvt_pkg::NUM_VERTS; v++) begin
                for (int c = 0; c < 3; c++) begin
                    r_vertex[v][c] <= bvt_pkg::corner_hi(bvt_pkg::VTX_W'(v), 2'(c))
                                      ? bvt_pkg::ONE_FX : bvt_pkg::NEG_ONE_FX;
                end
            end
        end else begin
            // configuration writes; indexes past the box maximum are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bvt_pkg::CFG_MIN_X: r_box_lo[0] <= i_cfg_data;
                    bvt_pkg::CFG_MIN_Y: r_box_lo[1] <= i_cfg_data;
                    bvt_pkg::CFG_MIN_Z: r_box_lo[2] <= i_cfg_data;
                    bvt_pkg::CFG_MAX_X: r_box_hi[0] <= i_cfg_data;
                    bvt_pkg::CFG_MAX_Y: r_box_hi[1] <= i_cfg_data;
                    bvt_pkg::CFG_MAX_Z: r_box_hi[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            // load one matrix row; row three is dropped
            if (w_accept && w_kind == bvt_pkg::REQ_LOAD &&
                w_row_in < 2'(bvt_pkg::NUM_ROWS)) begin
                for (int c = 0; c < bvt_pkg::NUM_COLS; c++) begin
                    r_matrix[w_row_in][c] <=
                        i_s_axis_tdata[c*bvt_pkg::WORD_W +: bvt_pkg::WORD_W];
                end
            end
            // store a transformed coordinate
            if (r_state == bvt_pkg::ST_STORE && r_apply) begin
                r_vertex[r_vtx][r_row] <= r_sat[bvt_pkg::WORD_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Counters, multiplier, accumulator and query tracking
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apply <= 1'b0;
            r_vtx   <= '0;
            r_row   <= '0;
            r_term  <= '0;
        end else begin
            case (r_state)
                bvt_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_apply <= (w_kind == bvt_pkg::REQ_APPLY);
                        r_vtx   <= '0;
                        r_row   <= '0;
                        r_term  <= '0;
                    end
                end
                bvt_pkg::ST_ACC: begin
                    if (r_term != bvt_pkg::LAST_TERM) begin
                        r_term <= r_term + 2'd1;
                    end
                end
                bvt_pkg::ST_STORE: begin
                    r_term <= '0;
                    if (r_apply && r_row != bvt_pkg::LAST_ROW) begin
                        r_row <= r_row + 2'd1;
                    end else begin
                        r_row <= '0;
                        r_vtx <= r_vtx + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        // latch the query axis
        if (w_accept && w_kind == bvt_pkg::REQ_QUERY) begin
            for (int c = 0; c < 3; c++) begin
                r_axis[c] <= i_s_axis_tdata[(4 + c)*bvt_pkg::WORD_W +: bvt_pkg::WORD_W];
            end
        end
        // one exact product per visit
        if (r_state == bvt_pkg::ST_MUL) begin
            r_prod <= w_op_a * w_op_b;
            r_vtmp[r_term] <= r_vertex[r_vtx][r_term];
        end
        // accumulate floored products from the translation term (apply) or zero (query)
        if (r_state == bvt_pkg::ST_ACC) begin
            r_acc <= ((r_term == '0) ? w_init : r_acc) + w_shp;
        end
        // clamp to the coordinate or projection range
        if (r_state == bvt_pkg::ST_SAT) begin
            if (r_acc > w_sat_hi) begin
                r_sat <= w_sat_hi;
            end else if (r_acc < w_sat_lo) begin
                r_sat <= w_sat_lo;
            end else begin
                r_sat <= r_acc;
            end
        end
        // track the interval; keep the earliest vertex on ties
        if (r_state == bvt_pkg::ST_STORE && !r_apply) begin
            if (r_vtx == '0) begin
                r_lo <= w_p;
                r_hi <= w_p;
                r_supp <= r_vtmp;
            end else begin
                if (w_p < r_lo) begin
                    r_lo <= w_p;
                end
                if (w_p > r_hi) begin
                    r_hi <= w_p;
                    r_supp <= r_vtmp;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_term <= bvt_pkg::LAST_TERM) && (r_row <= bvt_pkg::LAST_ROW))
        else $error("row or term counter out of range");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == bvt_pkg::ST_DONE)
        else $error("result posted outside the done state");

    a_start_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bvt_pkg::ST_IDLE && n_state != bvt_pkg::ST_IDLE) |-> w_accept)
        else $error("sequencer started without an accepted request");

endmodule
